// File: hdl/ffba_pkg.sv
package ffba_pkg;

  localparam int MEM_SIZE_BYTES_DEF = 4096;
  localparam int TABLE_ENTRIES_DEF = 16;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE = 2'd1;
  localparam logic [1:0] CMD_INIT = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  owner_id;
    logic [15:0] request_size;
  } in_req_t;

  typedef struct packed {
    logic       success;
    logic [3:0] block_index;
    logic [4:0] freed_count;
  } out_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SPLIT,
    ST_MARK,
    ST_MERGE,
    ST_DONE
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic init;
    logic scan_step;
    logic split_step;
    logic commit;
    logic mark_step;
    logic merge_step;
    logic fail;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad_size;
    logic scan_end;
    logic hit;
    logic exact;
    logic full;
    logic split_end;
    logic mark_end;
    logic any_freed;
    logic merge_end;
  } dp_status_t;

endpackage

// File: hdl/ffba_datapath.sv
module ffba_datapath #(
  parameter int MEM_SIZE_BYTES = ffba_pkg::MEM_SIZE_BYTES_DEF,
  parameter int TABLE_ENTRIES  = ffba_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ffba_pkg::in_req_t    in_req,
  input  ffba_pkg::dp_cmd_t    cmd,
  output ffba_pkg::dp_status_t status,
  output ffba_pkg::out_res_t   res
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int SW = $clog2(MEM_SIZE_BYTES + 1);

  logic [SW-1:0] start_r [TABLE_ENTRIES];
  logic [SW-1:0] size_r  [TABLE_ENTRIES];
  logic [7:0]    owner_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] free_r;
  logic [CW-1:0] used_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] j_r;
  logic [CW-1:0] freed_r;
  logic [7:0]    own_r;
  logic [15:0]   rsize_r;

  logic [IW-1:0] ii, ii1, jj, jm1, jj1;
  logic          cur_free, nxt_free;
  logic [SW-1:0] cur_size;

  assign ii  = idx_r[IW-1:0];
  assign ii1 = IW'(idx_r + CW'(1));
  assign jj  = j_r[IW-1:0];
  assign jm1 = IW'(j_r - CW'(1));
  assign jj1 = IW'(j_r + CW'(1));
  assign cur_free = free_r[ii];
  assign nxt_free = free_r[ii1];
  assign cur_size = size_r[ii];

  always_comb begin
    status.bad_size  = (rsize_r == 16'd0) || ({16'd0, rsize_r} > 32'(MEM_SIZE_BYTES));
    status.scan_end  = idx_r >= used_r;
    status.hit       = cur_free && ({{(32-SW){1'b0}}, cur_size} >= {16'd0, rsize_r});
    status.exact     = {{(32-SW){1'b0}}, cur_size} == {16'd0, rsize_r};
    status.full      = {{(32-CW){1'b0}}, used_r} >= 32'(TABLE_ENTRIES);
    status.split_end = j_r <= idx_r + CW'(1);
    status.mark_end  = idx_r >= used_r;
    status.any_freed = freed_r != '0;
    status.merge_end = idx_r + CW'(1) >= used_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r  <= TABLE_ENTRIES'(1);
      used_r  <= CW'(1);
      idx_r   <= '0;
      j_r     <= '0;
      freed_r <= '0;
      res     <= '0;
      start_r[0] <= '0;
      size_r[0]  <= SW'(MEM_SIZE_BYTES);
    end else begin
      if (cmd.load) begin
        idx_r   <= '0;
        j_r     <= used_r;
        freed_r <= '0;
        own_r   <= in_req.owner_id;
        rsize_r <= in_req.request_size;
        res     <= '0;
      end
      if (cmd.init) begin
        free_r     <= TABLE_ENTRIES'(1);
        used_r     <= CW'(1);
        start_r[0] <= '0;
        size_r[0]  <= SW'(MEM_SIZE_BYTES);
      end
      if (cmd.scan_step) idx_r <= idx_r + CW'(1);
      // open a slot after the hit by shifting the tail up one entry
      if (cmd.split_step) begin
        start_r[jj] <= start_r[jm1];
        size_r[jj]  <= size_r[jm1];
        owner_r[jj] <= owner_r[jm1];
        free_r[jj]  <= free_r[jm1];
        j_r         <= j_r - CW'(1);
      end
      if (cmd.commit) begin
        if (!status.exact) begin
          start_r[ii1] <= start_r[ii] + SW'(rsize_r);
          size_r[ii1]  <= cur_size - SW'(rsize_r);
          free_r[ii1]  <= 1'b1;
          used_r       <= used_r + CW'(1);
          size_r[ii]   <= SW'(rsize_r);
        end
        owner_r[ii]     <= own_r;
        free_r[ii]      <= 1'b0;
        res.success     <= 1'b1;
        res.block_index <= 4'(idx_r);
      end
      if (cmd.fail) res <= '0;
      if (cmd.mark_step) begin
        if (status.mark_end) begin
          idx_r <= '0;
          j_r   <= '0;
          res.freed_count <= 5'(freed_r);
        end else begin
          if (!cur_free && owner_r[ii] == own_r) begin
            free_r[ii] <= 1'b1;
            freed_r    <= freed_r + CW'(1);
          end
          idx_r <= idx_r + CW'(1);
        end
      end
      // merge a free pair into one block, then pull the tail down one entry at a time
      if (cmd.merge_step) begin
        if (j_r != '0) begin
          start_r[jj] <= start_r[jj1];
          size_r[jj]  <= size_r[jj1];
          owner_r[jj] <= owner_r[jj1];
          free_r[jj]  <= free_r[jj1];
          if (j_r + CW'(2) >= used_r) begin
            j_r    <= '0;
            used_r <= used_r - CW'(1);
          end else begin
            j_r <= j_r + CW'(1);
          end
        end else if (cur_free && nxt_free) begin
          size_r[ii] <= cur_size + size_r[ii1];
          if (idx_r + CW'(2) >= used_r) used_r <= used_r - CW'(1);
          else j_r <= idx_r + CW'(1);
        end else begin
          idx_r <= idx_r + CW'(1);
        end
      end
    end
  end

  ffba_split_bound_a: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && !status.exact |-> !status.full)
    else $error("split with full table");
  ffba_used_a: assert property (@(posedge clk) disable iff (!rst_n)
    used_r != '0 && {{(32-CW){1'b0}}, used_r} <= 32'(TABLE_ENTRIES))
    else $error("entry count out of range");
  ffba_fail_res_a: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fail |=> !res.success)
    else $error("failed alloc reports success");

endmodule

// File: hdl/ffba_ctrl.sv
module ffba_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [1:0]           command,
  input  ffba_pkg::dp_status_t status,
  output ffba_pkg::dp_cmd_t    cmd,
  output logic                 busy,
  output logic                 done
);

  ffba_pkg::ctrl_state_t state_r, state_nxt;
  logic [1:0] cmd_r;
  logic accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffba_pkg::ST_IDLE;
      cmd_r   <= ffba_pkg::CMD_ALLOC;
    end else begin
      state_r <= state_nxt;
      if (accept) cmd_r <= command;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffba_pkg::ST_IDLE: begin
        if (accept) begin
          if (command == ffba_pkg::CMD_ALLOC) state_nxt = ffba_pkg::ST_SCAN;
          else if (command == ffba_pkg::CMD_FREE) state_nxt = ffba_pkg::ST_MARK;
          else state_nxt = ffba_pkg::ST_DONE;
        end
      end
      ffba_pkg::ST_SCAN: begin
        if (status.bad_size || status.scan_end) state_nxt = ffba_pkg::ST_DONE;
        else if (status.hit) begin
          if (status.exact) state_nxt = ffba_pkg::ST_DONE;
          else if (status.full) state_nxt = ffba_pkg::ST_DONE;
          else state_nxt = ffba_pkg::ST_SPLIT;
        end
      end
      ffba_pkg::ST_SPLIT: if (status.split_end) state_nxt = ffba_pkg::ST_DONE;
      ffba_pkg::ST_MARK: begin
        if (status.mark_end)
          state_nxt = status.any_freed ? ffba_pkg::ST_MERGE : ffba_pkg::ST_DONE;
      end
      ffba_pkg::ST_MERGE: if (status.merge_end) state_nxt = ffba_pkg::ST_DONE;
      ffba_pkg::ST_DONE: state_nxt = ffba_pkg::ST_IDLE;
      default: state_nxt = ffba_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = state_r != ffba_pkg::ST_IDLE;
    done = state_r == ffba_pkg::ST_DONE;
    cmd.load = accept;
    cmd.init = accept && command == ffba_pkg::CMD_INIT;
    unique case (state_r)
      ffba_pkg::ST_SCAN: begin
        if (status.bad_size || status.scan_end) cmd.fail = 1'b1;
        else if (status.hit) begin
          if (status.exact) cmd.commit = 1'b1;
          else if (status.full) cmd.fail = 1'b1;
        end else cmd.scan_step = 1'b1;
      end
      ffba_pkg::ST_SPLIT: begin
        if (status.split_end) cmd.commit = 1'b1;
        else cmd.split_step = 1'b1;
      end
      ffba_pkg::ST_MARK:  cmd.mark_step = 1'b1;
      ffba_pkg::ST_MERGE: cmd.merge_step = !status.merge_end;
      default: ;
    endcase
  end

  ffba_done_a: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !busy)
    else $error("done not followed by idle");
  ffba_onecmd_a: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.commit, cmd.fail, cmd.split_step, cmd.scan_step}) <= 1)
    else $error("conflicting alloc commands");
  ffba_merge_a: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.merge_step |-> cmd_r == ffba_pkg::CMD_FREE)
    else $error("merge outside free");

endmodule

// File: hdl/first_fit_block_allocator.sv
// alloc: scan for the first fit, shift the tail up and commit for a split, then strobe
// free: mark the owner's entries, then, if any were freed, merge pulls the tail down one entry a cycle
// init and unused commands: strobe in the cycle after accept, then the controller returns to idle
// one request at a time, busy high through the strobe; the receiver cannot stall the strobe
// reset: table holds one free block covering all memory, controller idle
module first_fit_block_allocator #(
  parameter int MEM_SIZE_BYTES = ffba_pkg::MEM_SIZE_BYTES_DEF,
  parameter int TABLE_ENTRIES  = ffba_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ffba_pkg::in_req_t  in_req,
  output logic               out_strobe,
  output ffba_pkg::out_res_t out_res
);

  ffba_pkg::dp_cmd_t    cmd;
  ffba_pkg::dp_status_t status;

  ffba_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .command (in_req.command),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy),
    .done    (out_strobe)
  );

  ffba_datapath #(
    .MEM_SIZE_BYTES (MEM_SIZE_BYTES),
    .TABLE_ENTRIES  (TABLE_ENTRIES)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .cmd    (cmd),
    .status (status),
    .res    (out_res)
  );

endmodule

// File: tb/sv/testbench.sv
module testbench;

  localparam int MEM_BYTES = ffba_pkg::MEM_SIZE_BYTES_DEF;
  localparam int SLOTS = ffba_pkg::TABLE_ENTRIES_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  ffba_pkg::in_req_t in_req = '0;
  logic out_strobe;
  ffba_pkg::out_res_t out_res;

  first_fit_block_allocator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_strobe(out_strobe), .out_res(out_res)
  );

  always #10 clk = ~clk;

  // predicted allocator table
  logic [11:0] blk_start [SLOTS];
  logic [12:0] blk_size [SLOTS];
  logic [7:0]  blk_owner [SLOTS];
  logic        blk_free [SLOTS];
  int          blk_count;

  ffba_pkg::out_res_t pending_res [$];
  int errors = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int allocs_ok = 0;
  int frees_hit = 0;
  int cycles = 0;
  bit quiet = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic void table_reset();
    for (int k = 0; k < SLOTS; k++) begin
      blk_start[k] = '0; blk_size[k] = '0; blk_owner[k] = '0; blk_free[k] = 1'b0;
    end
    blk_size[0] = 13'(MEM_BYTES);
    blk_free[0] = 1'b1;
    blk_count = 1;
  endfunction

  function automatic void slot_copy(int d, int s);
    blk_start[d] = blk_start[s]; blk_size[d] = blk_size[s];
    blk_owner[d] = blk_owner[s]; blk_free[d] = blk_free[s];
  endfunction

  function automatic ffba_pkg::out_res_t allocate(logic [7:0] who, logic [15:0] sz);
    ffba_pkg::out_res_t r;
    r = '0;
    if (sz == 0 || sz > MEM_BYTES) return r;
    for (int i = 0; i < blk_count; i++) begin
      if (blk_free[i] && blk_size[i] >= sz) begin
        if (blk_size[i] != sz) begin
          if (blk_count >= SLOTS) return r;
          for (int j = blk_count; j > i + 1; j--) slot_copy(j, j - 1);
          blk_owner[i+1] = '0;
          blk_start[i+1] = blk_start[i] + sz[11:0];
          blk_size[i+1] = blk_size[i] - sz[12:0];
          blk_free[i+1] = 1'b1;
          blk_count++;
          blk_size[i] = sz[12:0];
        end
        blk_owner[i] = who;
        blk_free[i] = 1'b0;
        r.success = 1'b1;
        r.block_index = 4'(i);
        return r;
      end
    end
    return r;
  endfunction

  function automatic int release_owner(logic [7:0] who);
    int n, i;
    n = 0;
    for (i = 0; i < blk_count; i++)
      if (!blk_free[i] && blk_owner[i] == who) begin
        blk_free[i] = 1'b1; blk_owner[i] = '0; n++;
      end
    if (n > 0) begin
      i = 0;
      while (i + 1 < blk_count) begin
        if (blk_free[i] && blk_free[i+1]) begin
          blk_size[i] = blk_size[i] + blk_size[i+1];
          for (int j = i + 1; j + 1 < blk_count; j++) slot_copy(j, j + 1);
          blk_count--;
        end else i++;
      end
    end
    return n;
  endfunction

  function automatic ffba_pkg::out_res_t predict(ffba_pkg::in_req_t q);
    ffba_pkg::out_res_t r;
    r = '0;
    case (q.command)
      ffba_pkg::CMD_ALLOC: r = allocate(q.owner_id, q.request_size);
      ffba_pkg::CMD_FREE: r.freed_count = 5'(release_owner(q.owner_id));
      ffba_pkg::CMD_INIT: table_reset();
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_request(input logic [1:0] cmd, input logic [7:0] who,
                              input logic [15:0] sz);
    ffba_pkg::in_req_t q;
    q.command = cmd; q.owner_id = who; q.request_size = sz;
    if (!quiet && $urandom_range(99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_req <= q;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge
    pending_res.push_back(predict(q));
    if (q.command == ffba_pkg::CMD_ALLOC && pending_res[$].success) allocs_ok++;
    if (pending_res[$].freed_count != 0) frees_hit++;
    requests_sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      ffba_pkg::out_res_t e;
      results_seen++;
      if (pending_res.size() == 0) report("result with no request outstanding");
      else begin
        e = pending_res.pop_front();
        if (out_res.success !== e.success)
          report($sformatf("success got %b want %b", out_res.success, e.success));
        if (out_res.block_index !== e.block_index)
          report($sformatf("block_index got %0d want %0d", out_res.block_index,
                 e.block_index));
        if (out_res.freed_count !== e.freed_count)
          report($sformatf("freed_count got %0d want %0d", out_res.freed_count,
                 e.freed_count));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** first_fit_block_allocator: FAILED **");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(ffba_pkg::CMD_ALLOC, 8'h01, 16'd0);        // bad size, zero
    send_request(ffba_pkg::CMD_ALLOC, 8'h01, 16'(MEM_BYTES + 1)); // bad size, too big
    send_request(ffba_pkg::CMD_ALLOC, 8'hFF, 16'hFFFF);
    send_request(ffba_pkg::CMD_FREE, 8'h07, 16'd0);         // nothing owned
    send_request(ffba_pkg::CMD_ALLOC, 8'h00, 16'(MEM_BYTES)); // exact whole memory
    send_request(ffba_pkg::CMD_ALLOC, 8'h02, 16'd1);        // no fit
    send_request(ffba_pkg::CMD_FREE, 8'h00, 16'hFFFF);
    send_request(CMD_UNUSED, 8'hAA, 16'h5555);
    // fill the table with splits until full
    for (int k = 0; k < SLOTS; k++) send_request(ffba_pkg::CMD_ALLOC, 8'(k & 3), 16'd1);
    send_request(ffba_pkg::CMD_FREE, 8'h01, 16'd0);
    send_request(ffba_pkg::CMD_ALLOC, 8'h09, 16'd2);        // table full on a split
    send_request(ffba_pkg::CMD_ALLOC, 8'h09, 16'd1);        // exact fit on freed hole
    send_request(ffba_pkg::CMD_INIT, 8'hFF, 16'hFFFF);
  endtask

  task automatic test_random(input int n);
    logic [1:0] cmd;
    logic [15:0] sz;
    for (int k = 0; k < n; k++) begin
      quiet = (k >= n / 3 && k < n / 2);
      case ($urandom_range(99)) inside
        [0:54]: cmd = ffba_pkg::CMD_ALLOC;
        [55:89]: cmd = ffba_pkg::CMD_FREE;
        [90:95]: cmd = ffba_pkg::CMD_INIT;
        default: cmd = CMD_UNUSED;
      endcase
      case ($urandom_range(9))
        0: sz = 16'($urandom);
        1: sz = 16'($urandom_range(MEM_BYTES / 2, MEM_BYTES));
        2, 3: sz = 16'($urandom_range(1, 8));
        default: sz = 16'($urandom_range(1, 600));
      endcase
      send_request(cmd, $urandom_range(9) == 0 ? 8'($urandom) : 8'($urandom_range(7)), sz);
    end
    quiet = 0;
  endtask

  initial begin
    table_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(2000);
    start <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (4 * SLOTS + 8) @(posedge clk);
    $display("sent %0d requests, checked %0d results", requests_sent, results_seen);
    $display("%0d allocations succeeded, %0d frees released blocks", allocs_ok, frees_hit);
    if (errors == 0) $display("** first_fit_block_allocator: PASSED **");
    else $display("** first_fit_block_allocator: FAILED **");
    $finish;
  end
endmodule

// File: first_fit_block_allocator.f
hdl/ffba_pkg.sv
hdl/ffba_datapath.sv
hdl/ffba_ctrl.sv
hdl/first_fit_block_allocator.sv
tb/sv/testbench.sv
